>>> design/dcbf_pkg.sv
// dcbf_pkg: shared types and constants for the DC blocking filter.
// Depends on nothing; used by dc_blocking_filter.
package dcbf_pkg;

  // Field widths
  localparam int unsigned DataW    = 32;
  localparam int unsigned ChW      = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Default channel count and number of coefficient registers
  localparam int unsigned NumChannelsDef = 4;
  localparam int unsigned NumCoefs       = 4;

  // Sample format codes
  typedef enum logic [1:0] {
    Fmt16 = 2'd0,
    Fmt24 = 2'd1,
    Fmt32 = 2'd2
  } fmt_e;

  // Register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegSampleFormat = 3'd0,
    RegCoefCh0      = 3'd1,
    RegCoefCh1      = 3'd2,
    RegCoefCh2      = 3'd3,
    RegCoefCh3      = 3'd4
  } cfg_reg_e;

endpackage

>>> design/dcbf_ram.sv
// dcbf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies. Read data holds when no read is issued.
module dcbf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/dc_blocking_filter.sv
// dc_blocking_filter: per-channel first-order DC blocking filter, top level.
// Depends on dcbf_pkg and dcbf_ram.
//
//   Channel   Handshake                  Payload
//   input     in_valid_i / in_stall_o    channel_i, sample_in_i, period_end_i
//   output    out_valid_o / out_stall_i  channel_out_o, sample_out_o, period_end_out_o
//   config    cfg_we_i (write only)      cfg_index_i, cfg_data_i
//
// One transaction per cycle while neither out_stall_i nor a same-channel wait
// holds it; an accepted input moves through the stage 1, stage 2 and output
// registers in that order. A transaction on the same channel as the one
// directly ahead of it waits in stage 1: the state RAM read-modify-write loop
// spans the multiplier register and the writeback stage. Reset clears control
// and a valid flag per channel; an unwritten state entry reads as zero, so
// there is no clearing pass. out_stall_i backs up through the pipeline into in_stall_o in the same cycle.
module dc_blocking_filter #(
  parameter int unsigned NumChannels = dcbf_pkg::NumChannelsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dcbf_pkg::ChW-1:0]            channel_i,
  input  logic signed [dcbf_pkg::DataW-1:0]   sample_in_i,
  input  logic                                period_end_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [dcbf_pkg::ChW-1:0]            channel_out_o,
  output logic signed [dcbf_pkg::DataW-1:0]   sample_out_o,
  output logic                                period_end_out_o,
  // Configuration
  input  logic                                cfg_we_i,
  input  logic [dcbf_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [dcbf_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned AddrW = (NumChannels > 1) ? $clog2(NumChannels) : 1;
  localparam int unsigned DW    = dcbf_pkg::DataW;
  localparam int unsigned WordW = 2 * DW;

  // Configuration registers
  dcbf_pkg::fmt_e           fmt_q;
  logic signed [DW-1:0]     coef_q [dcbf_pkg::NumCoefs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= dcbf_pkg::Fmt16;
      for (int i = 0; i < int'(dcbf_pkg::NumCoefs); i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        dcbf_pkg::RegSampleFormat: begin
          fmt_q <= dcbf_pkg::fmt_e'(cfg_data_i[1:0]);
        end
        dcbf_pkg::RegCoefCh0, dcbf_pkg::RegCoefCh1,
        dcbf_pkg::RegCoefCh2, dcbf_pkg::RegCoefCh3: begin
          coef_q[2'(cfg_index_i - dcbf_pkg::RegCoefCh0)] <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline registers
  logic                   s1_v_q, s1_ok_q, s1_pe_q, s1_rv_q, s1_fv_q;
  logic [1:0]             s1_ch_q;
  logic signed [DW-1:0]   s1_x_q;
  logic [WordW-1:0]       s1_fd_q;

  logic                   s2_v_q, s2_ok_q, s2_pe_q;
  logic [1:0]             s2_ch_q;
  logic signed [DW-1:0]   s2_x_q;
  logic signed [DW:0]     s2_diff_q;
  logic signed [34:0]     s2_prod_q;

  logic                   out_v_q, out_pe_q;
  logic [1:0]             out_ch_q;
  logic signed [DW-1:0]   out_y_q;

  logic [NumChannels-1:0] vld_q;

  // Handshake and pipeline advance
  logic in_acc, adv1, adv2, s2_free, hazard, wr_en;
  logic in_ok;
  logic [AddrW-1:0] addr_in;

  assign in_ok   = int'(channel_i) < int'(NumChannels);
  assign addr_in = AddrW'(channel_i);

  assign adv2       = s2_v_q & (~out_v_q | ~out_stall_i);
  assign s2_free    = ~s2_v_q | adv2;
  assign hazard     = s2_v_q & s2_ok_q & (s1_ch_q == s2_ch_q);
  assign adv1       = s1_v_q & s2_free & ~hazard;
  assign in_stall_o = s1_v_q & ~adv1;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign wr_en      = adv2 & s2_ok_q;

  // Input alignment to Q1.31
  logic signed [DW-1:0] x_in;

  always_comb begin
    unique case (fmt_q)
      dcbf_pkg::Fmt16: x_in = {sample_in_i[15:0], 16'h0000};
      dcbf_pkg::Fmt24: x_in = {sample_in_i[23:0], 8'h00};
      default:         x_in = sample_in_i;
    endcase
  end

  // State RAM: {prev_input, prev_output} per channel
  logic [WordW-1:0] ram_rdata, wr_data;
  logic signed [DW-1:0] s2_y;

  assign wr_data = {s2_x_q, s2_y};

  dcbf_ram #(
    .Width (WordW),
    .Depth (NumChannels),
    .AddrW (AddrW)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AddrW'(s2_ch_q)),
    .wdata_i (wr_data),
    .re_i    (in_acc),
    .raddr_i (addr_in),
    .rdata_o (ram_rdata)
  );

  // Stage 1: operand select with forwarding, multiply, difference
  logic [WordW-1:0]       s1_state;
  logic signed [DW-1:0]   s1_xp, s1_yp, s1_coef;
  logic signed [WordW-1:0] s1_prod;
  logic signed [DW:0]     s1_diff;

  assign s1_state = s1_fv_q ? s1_fd_q : (s1_rv_q ? ram_rdata : '0);
  assign s1_xp    = s1_state[WordW-1:DW];
  assign s1_yp    = s1_state[DW-1:0];
  assign s1_coef  = coef_q[s1_ch_q];
  assign s1_prod  = s1_coef * s1_yp;
  assign s1_diff  = (DW+1)'(s1_x_q) - (DW+1)'(s1_xp);

  // Stage 2: round product Q61 -> Q31, accumulate, saturate
  logic signed [35:0] s2_rnd_t, s2_acc;
  logic signed [34:0] s2_rnd;

  assign s2_rnd_t = 36'(s2_prod_q) + 36'sd1;
  assign s2_rnd   = $signed(s2_rnd_t[35:1]);
  assign s2_acc   = 36'(s2_diff_q) + 36'(s2_rnd);

  always_comb begin
    if ((&s2_acc[35:31]) | ~(|s2_acc[35:31])) begin
      s2_y = s2_acc[31:0];
    end else if (s2_acc[35]) begin
      s2_y = 32'sh8000_0000;
    end else begin
      s2_y = 32'sh7fff_ffff;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s1_fv_q <= 1'b0;
      s1_rv_q <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      vld_q   <= '0;
    end else begin
      if (in_acc) begin
        s1_v_q  <= 1'b1;
        s1_rv_q <= in_ok & vld_q[addr_in];
        s1_fv_q <= wr_en & (s2_ch_q == channel_i);
      end else begin
        if (adv1) s1_v_q <= 1'b0;
        if (wr_en && (s2_ch_q == s1_ch_q)) s1_fv_q <= 1'b1;
      end
      if (adv1) begin
        s2_v_q <= 1'b1;
      end else if (adv2) begin
        s2_v_q <= 1'b0;
      end
      if (adv2) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (wr_en) begin
        vld_q[AddrW'(s2_ch_q)] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ch_q <= channel_i;
      s1_ok_q <= in_ok;
      s1_pe_q <= period_end_i;
      s1_x_q  <= x_in;
    end
    // forwarded write data for the item entering or waiting in stage 1
    if (wr_en && ((in_acc && (s2_ch_q == channel_i)) ||
                  (!in_acc && (s2_ch_q == s1_ch_q)))) begin
      s1_fd_q <= wr_data;
    end
    if (adv1) begin
      s2_ch_q   <= s1_ch_q;
      s2_ok_q   <= s1_ok_q;
      s2_pe_q   <= s1_pe_q;
      s2_x_q    <= s1_x_q;
      s2_diff_q <= s1_diff;
      s2_prod_q <= s1_prod[63:29];
    end
    if (adv2) begin
      out_ch_q <= s2_ch_q;
      out_pe_q <= s2_pe_q;
      out_y_q  <= s2_ok_q ? s2_y : '0;
    end
  end

  // Output rounding to the format width and saturation
  logic signed [17:0] t16;
  logic signed [16:0] r16;
  logic signed [15:0] q16;
  logic signed [25:0] t24;
  logic signed [24:0] r24;
  logic signed [23:0] q24;

  assign t16 = 18'($signed(out_y_q[31:15])) + 18'sd1;
  assign r16 = $signed(t16[17:1]);
  assign t24 = 26'($signed(out_y_q[31:7])) + 26'sd1;
  assign r24 = $signed(t24[25:1]);

  always_comb begin
    if (r16[16] == r16[15]) begin
      q16 = r16[15:0];
    end else begin
      q16 = r16[16] ? 16'sh8000 : 16'sh7fff;
    end
    if (r24[24] == r24[23]) begin
      q24 = r24[23:0];
    end else begin
      q24 = r24[24] ? 24'sh80_0000 : 24'sh7f_ffff;
    end
  end

  always_comb begin
    unique case (fmt_q)
      dcbf_pkg::Fmt16: sample_out_o = DW'(q16);
      dcbf_pkg::Fmt24: sample_out_o = DW'(q24);
      default:         sample_out_o = out_y_q;
    endcase
  end

  assign out_valid_o      = out_v_q;
  assign channel_out_o    = out_ch_q;
  assign period_end_out_o = out_pe_q;

endmodule
